// ===== rtl/core/tdbq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdbq_pkg
// Types, constants and helpers for the tail-drop buffer queue model.
// ----------------------------------------------------------------------------
package tdbq_pkg;

	localparam int TIME_W  = 48;
	localparam int SIZE_W  = 16;
	localparam int SEL_W   = 4;
	localparam int CNT_O_W = 8;
	localparam int BYT_O_W = 23;
	localparam int STAT_W  = 64;
	localparam int TPB_W   = 20;
	localparam int CAP_W   = 8;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(100);
	localparam logic [TPB_W-1:0] TPB_RST = TPB_W'(1600);

	// register map, index taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_TPB      = 1'b1;

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef enum logic [1:0] {
		ST_ACCEPT = 2'd0,
		ST_DROP   = 2'd1,
		ST_READ   = 2'd2
	} status_t;

	// statistic counter slots
	localparam int STAT_RX_PKTS    = 0;
	localparam int STAT_RX_BYTES   = 1;
	localparam int STAT_TX_PKTS    = 2;
	localparam int STAT_TX_BYTES   = 3;
	localparam int STAT_LOST_PKTS  = 4;
	localparam int STAT_LOST_BYTES = 5;
	localparam int STAT_BUF_PKTS   = 6;
	localparam int STAT_BUF_BYTES  = 7;
	localparam int STAT_PEAK_OCC   = 8;
	localparam int STAT_PEAK_BYTES = 9;
	localparam int STAT_OCC_SUM    = 10;
	localparam int STAT_BYTES_SUM  = 11;
	localparam int STAT_DELAY_SUM  = 12;
	localparam int STAT_NUM        = 13;
	localparam int STAT_CUR_TIME   = 13;

	typedef struct packed {
		status_t              status;
		logic [TIME_W-1:0]    departure_time;
		logic [CNT_O_W-1:0]   retired_count;
		logic [CNT_O_W-1:0]   occupancy;
		logic [BYT_O_W-1:0]   buffered_bytes;
		logic [STAT_W-1:0]    stat_value;
	} rsp_t;

	function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
		input logic [STAT_W-1:0] b);
		logic [STAT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tdbq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdbq_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface tdbq_req_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [tdbq_pkg::TIME_W-1:0] event_time;
	logic [tdbq_pkg::SIZE_W-1:0] packet_size;
	logic [tdbq_pkg::SEL_W-1:0]  stat_select;

	modport source (output valid, op, event_time, packet_size, stat_select, input ready);
	modport sink (input valid, op, event_time, packet_size, stat_select, output ready);
endinterface

interface tdbq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic [tdbq_pkg::TIME_W-1:0]  departure_time;
	logic [tdbq_pkg::CNT_O_W-1:0] retired_count;
	logic [tdbq_pkg::CNT_O_W-1:0] occupancy;
	logic [tdbq_pkg::BYT_O_W-1:0] buffered_bytes;
	logic [tdbq_pkg::STAT_W-1:0]  stat_value;

	modport source (output valid, status, departure_time, retired_count, occupancy,
		buffered_bytes, stat_value, input ready);
	modport sink (input valid, status, departure_time, retired_count, occupancy,
		buffered_bytes, stat_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tdbq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdbq_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tdbq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/tail_drop_buffer_queue_model_top.sv =====
// Flow: a transaction is taken in S_IDLE, retires due departures in S_CHK, passes
// through S_MUL1 and S_MUL2 (accepted arrivals only) and reaches S_FIN, where the
// response is registered once the output register is free; no new transaction is
// taken before that. Retirement walks the departure RAM one entry per cycle.
// Reset: arst_n clears queue pointers, counts and statistics; RAM is not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// tail_drop_buffer_queue_model_top
// Tail-drop packet buffer drained at a fixed link rate, with saturating
// running statistics and an APB register port.
// ----------------------------------------------------------------------------
module tail_drop_buffer_queue_model_top #(
	parameter int DEPTH = 128
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tdbq_req_if.sink                           req,
	tdbq_rsp_if.source                         rsp,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tdbq_pkg::APB_AW-1:0]   paddr,
	input  wire logic [tdbq_pkg::APB_DW-1:0]   pwdata,
	output      logic [tdbq_pkg::APB_DW-1:0]   prdata,
	output      logic                          pready
);
	import tdbq_pkg::*;

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int BW    = $clog2(DEPTH * (2 ** SIZE_W - 1) + 1);
	localparam int PW    = BW + TPB_W;
	localparam int SUM_W = ((PW > TIME_W) ? PW : TIME_W) + 1;
	localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;
	localparam int RW    = TIME_W + SIZE_W;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CHK  = 5'b00010,
		S_MUL1 = 5'b00100,
		S_MUL2 = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t              state_q;
	logic [CAP_W-1:0]    capacity_q;
	logic [TPB_W-1:0]    tpb_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [CW-1:0]       count_q;
	logic [BW-1:0]       bytes_q;
	logic [CW-1:0]       retired_q;
	logic [TIME_W-1:0]   cur_time_q;
	logic [STAT_W-1:0]   stat_q [STAT_NUM];

	logic                op_q;
	logic [TIME_W-1:0]   t_q;
	logic [SIZE_W-1:0]   size_q;
	logic [SEL_W-1:0]    sel_q;
	status_t             status_q;
	logic [PW-1:0]       mul_q;
	logic [TIME_W-1:0]   dep_q;

	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                cfg_wr;
	logic [AW-1:0]       head_nxt;
	logic [AW-1:0]       tail_nxt;
	logic [AW-1:0]       rd_addr;
	logic [RW-1:0]       rd_data;
	logic [TIME_W-1:0]   rd_time;
	logic [SIZE_W-1:0]   rd_size;
	logic                retire;
	logic [CMP_W-1:0]    cap_eff;
	logic                full;
	logic [BW-1:0]       mul_b;
	logic [PW-1:0]       mul_res;
	logic [SUM_W-1:0]    dep_sum;
	logic [TIME_W-1:0]   dep_sat;
	logic                ram_we;
	logic                out_free;
	logic                out_load;
	logic [STAT_W-1:0]   sel_value;
	rsp_t                rsp_d;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_TPB) ? APB_DW'(tpb_q) : APB_DW'(capacity_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RST;
			tpb_q      <= TPB_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_TPB) begin
				tpb_q <= pwdata[TPB_W-1:0];
			end else begin
				capacity_q <= pwdata[CAP_W-1:0];
			end
		end
	end

	// departure FIFO store: {time, size}
	assign head_nxt = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign rd_time  = rd_data[RW-1:SIZE_W];
	assign rd_size  = rd_data[SIZE_W-1:0];
	assign retire   = (state_q == S_CHK) && (count_q != '0) && (rd_time <= t_q);
	assign rd_addr  = retire ? head_nxt : head_q;
	assign ram_we   = (state_q == S_MUL2);

	tdbq_ram #(
		.WIDTH(RW),
		.DEPTH(DEPTH)
	) u_dep_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata({dep_sat, size_q}),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign cap_eff = (CMP_W'(capacity_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity_q);
	assign full    = CMP_W'(count_q) >= cap_eff;

	// shared multiplier: new bytes for departure, old bytes for queuing delay
	assign mul_b   = (state_q == S_MUL2) ? bytes_q - BW'(size_q) : bytes_q;
	assign mul_res = PW'(mul_b) * PW'(tpb_q);
	assign dep_sum = SUM_W'(t_q) + SUM_W'(mul_q);
	assign dep_sat = (dep_sum[SUM_W-1:TIME_W] != '0) ? TIME_MAX : dep_sum[TIME_W-1:0];

	assign out_free = !rsp_valid_q || rsp.ready;
	assign out_load = (state_q == S_FIN) && out_free;
	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		sel_value = '0;
		if (sel_q < SEL_W'(STAT_NUM)) begin
			sel_value = stat_q[sel_q];
		end else if (sel_q == SEL_W'(STAT_CUR_TIME)) begin
			sel_value = STAT_W'(cur_time_q);
		end
	end

	always_comb begin
		rsp_d.status         = status_q;
		rsp_d.departure_time = (status_q == ST_ACCEPT) ? dep_q : '0;
		rsp_d.retired_count  = CNT_O_W'(retired_q);
		rsp_d.occupancy      = CNT_O_W'(count_q);
		rsp_d.buffered_bytes = BYT_O_W'(bytes_q);
		rsp_d.stat_value     = (status_q == ST_READ) ? sel_value : '0;
	end

	// control and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			bytes_q    <= '0;
			retired_q  <= '0;
			cur_time_q <= '0;
			for (int i = 0; i < STAT_NUM; i++) begin
				stat_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						retired_q <= '0;
						state_q   <= S_CHK;
					end
				end
				S_CHK: begin
					if (retire) begin
						stat_q[STAT_OCC_SUM]   <= sat_add(stat_q[STAT_OCC_SUM], STAT_W'(count_q));
						stat_q[STAT_BYTES_SUM] <= sat_add(stat_q[STAT_BYTES_SUM], STAT_W'(bytes_q));
						stat_q[STAT_TX_PKTS]   <= sat_add(stat_q[STAT_TX_PKTS], STAT_W'(1));
						stat_q[STAT_TX_BYTES]  <= sat_add(stat_q[STAT_TX_BYTES], STAT_W'(rd_size));
						count_q   <= count_q - 1'b1;
						bytes_q   <= (bytes_q >= BW'(rd_size)) ? bytes_q - BW'(rd_size) : '0;
						head_q    <= head_nxt;
						retired_q <= retired_q + 1'b1;
					end else begin
						cur_time_q <= t_q;
						if (op_q == OP_READ) begin
							state_q <= S_FIN;
						end else begin
							stat_q[STAT_RX_PKTS]  <= sat_add(stat_q[STAT_RX_PKTS], STAT_W'(1));
							stat_q[STAT_RX_BYTES] <= sat_add(stat_q[STAT_RX_BYTES], STAT_W'(size_q));
							if (full) begin
								stat_q[STAT_LOST_PKTS]  <= sat_add(stat_q[STAT_LOST_PKTS], STAT_W'(1));
								stat_q[STAT_LOST_BYTES] <= sat_add(stat_q[STAT_LOST_BYTES],
									STAT_W'(size_q));
								state_q <= S_FIN;
							end else begin
								stat_q[STAT_BUF_PKTS]  <= sat_add(stat_q[STAT_BUF_PKTS], STAT_W'(1));
								stat_q[STAT_BUF_BYTES] <= sat_add(stat_q[STAT_BUF_BYTES],
									STAT_W'(size_q));
								count_q <= count_q + 1'b1;
								bytes_q <= bytes_q + BW'(size_q);
								state_q <= S_MUL1;
							end
						end
					end
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					tail_q  <= tail_nxt;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						if (status_q == ST_ACCEPT) begin
							stat_q[STAT_DELAY_SUM] <= sat_add(stat_q[STAT_DELAY_SUM], STAT_W'(mul_q));
							if (STAT_W'(count_q) > stat_q[STAT_PEAK_OCC]) begin
								stat_q[STAT_PEAK_OCC] <= STAT_W'(count_q);
							end
							if (STAT_W'(bytes_q) > stat_q[STAT_PEAK_BYTES]) begin
								stat_q[STAT_PEAK_BYTES] <= STAT_W'(bytes_q);
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// transaction payload and datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req.valid) begin
			op_q   <= req.op;
			t_q    <= req.event_time;
			size_q <= req.packet_size;
			sel_q  <= req.stat_select;
		end
		if ((state_q == S_CHK) && !retire) begin
			if (op_q == OP_READ) begin
				status_q <= ST_READ;
			end else if (full) begin
				status_q <= ST_DROP;
			end else begin
				status_q <= ST_ACCEPT;
			end
		end
		if ((state_q == S_MUL1) || (state_q == S_MUL2)) begin
			mul_q <= mul_res;
		end
		if (state_q == S_MUL2) begin
			dep_q <= dep_sat;
		end
		if (out_load) begin
			rsp_q <= rsp_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_q.status;
	assign rsp.departure_time = rsp_q.departure_time;
	assign rsp.retired_count  = rsp_q.retired_count;
	assign rsp.occupancy      = rsp_q.occupancy;
	assign rsp.buffered_bytes = rsp_q.buffered_bytes;
	assign rsp.stat_value     = rsp_q.stat_value;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("pointers disagree on empty queue");

	a_empty_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (bytes_q == '0))
		else $error("bytes left in empty queue");

	a_mul_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL1) |-> (count_q != '0))
		else $error("departure computed for empty queue");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> rsp_valid_q && (state_q == S_IDLE))
		else $error("result not presented after completion");

endmodule
`default_nettype wire

// ===== tb/sv/tail_drop_buffer_queue_model_top_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tail_drop_buffer_queue_model_top_test
// Drives arrival and statistic-read transactions into the tail-drop buffer,
// predicts every response with a cycle-free queue model kept in the bench,
// and compares each response field by field. Covers register access,
// departure saturation, zero capacity and zero rate, a full buffer under
// receiver back-pressure and randomised traffic over several settings.
// ----------------------------------------------------------------------------
module tail_drop_buffer_queue_model_top_test;
	import tdbq_pkg::*;

	localparam int          DEPTH         = 128;
	localparam int          SETTLE_CYCLES = 140;
	localparam int          HOLD_CYCLES   = 800;
	localparam longint      CYCLE_LIMIT   = 400000;
	localparam logic [APB_AW-1:0] ADDR_CAP = {REG_CAPACITY, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_TPB = {REG_TPB, 2'b00};

	typedef struct {
		logic              op;
		logic [TIME_W-1:0] t;
		logic [SIZE_W-1:0] size;
		logic [SEL_W-1:0]  sel;
	} pkt_event_t;

	typedef struct {
		logic [TIME_W-1:0] dep;
		logic [SIZE_W-1:0] size;
	} queued_pkt_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	tdbq_req_if req_ch();
	tdbq_rsp_if rsp_ch();

	tail_drop_buffer_queue_model_top #(
		.DEPTH(DEPTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// buffer model state
	logic [CAP_W-1:0]  cap_reg = CAP_RST;
	logic [TPB_W-1:0]  tpb_reg = TPB_RST;
	queued_pkt_t       link_q[$];
	logic [63:0]       byte_cnt = '0;
	logic [TIME_W-1:0] cur_time = '0;
	logic [STAT_W-1:0] stat_ctr [STAT_NUM];

	rsp_t              pending_rsp[$];
	int                errors = 0;
	longint            cycles = 0;
	int                idle_pct = 0;
	int                stall_pct = 0;
	logic              hold_rx = 1'b0;
	logic [63:0]       now = '0;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_ch.ready <= !hold_rx && ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [STAT_W-1:0] sum_sat(input logic [STAT_W-1:0] a,
		input logic [STAT_W-1:0] b);
		return (a > ~b) ? {STAT_W{1'b1}} : a + b;
	endfunction

	function automatic rsp_t buffer_step(input pkt_event_t ev);
		rsp_t        r;
		logic [63:0] drain_t;
		logic [63:0] dep;
		logic [7:0]  n_ret;
		int unsigned eff_cap;
		queued_pkt_t head;
		n_ret = '0;
		dep = '0;
		while (link_q.size() != 0 && link_q[0].dep <= ev.t) begin
			stat_ctr[STAT_OCC_SUM] = sum_sat(stat_ctr[STAT_OCC_SUM], 64'(link_q.size()));
			stat_ctr[STAT_BYTES_SUM] = sum_sat(stat_ctr[STAT_BYTES_SUM], byte_cnt);
			head = link_q.pop_front();
			stat_ctr[STAT_TX_PKTS] = sum_sat(stat_ctr[STAT_TX_PKTS], 64'd1);
			stat_ctr[STAT_TX_BYTES] = sum_sat(stat_ctr[STAT_TX_BYTES], 64'(head.size));
			byte_cnt = (byte_cnt >= 64'(head.size)) ? byte_cnt - 64'(head.size) : '0;
			n_ret++;
		end
		cur_time = ev.t;
		r = '0;
		r.status = ST_READ;
		if (ev.op == OP_ARRIVE) begin
			eff_cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
			stat_ctr[STAT_RX_PKTS] = sum_sat(stat_ctr[STAT_RX_PKTS], 64'd1);
			stat_ctr[STAT_RX_BYTES] = sum_sat(stat_ctr[STAT_RX_BYTES], 64'(ev.size));
			if (link_q.size() >= eff_cap) begin
				r.status = ST_DROP;
				stat_ctr[STAT_LOST_PKTS] = sum_sat(stat_ctr[STAT_LOST_PKTS], 64'd1);
				stat_ctr[STAT_LOST_BYTES] = sum_sat(stat_ctr[STAT_LOST_BYTES], 64'(ev.size));
			end else begin
				r.status = ST_ACCEPT;
				byte_cnt = byte_cnt + 64'(ev.size);
				stat_ctr[STAT_BUF_PKTS] = sum_sat(stat_ctr[STAT_BUF_PKTS], 64'd1);
				stat_ctr[STAT_BUF_BYTES] = sum_sat(stat_ctr[STAT_BUF_BYTES], 64'(ev.size));
				drain_t = byte_cnt * 64'(tpb_reg);
				dep = (drain_t > 64'(TIME_MAX) - 64'(ev.t)) ? 64'(TIME_MAX)
					: 64'(ev.t) + drain_t;
				stat_ctr[STAT_DELAY_SUM] = sum_sat(stat_ctr[STAT_DELAY_SUM],
					(byte_cnt - 64'(ev.size)) * 64'(tpb_reg));
				head.dep = dep[TIME_W-1:0];
				head.size = ev.size;
				link_q.push_back(head);
				if (64'(link_q.size()) > stat_ctr[STAT_PEAK_OCC])
					stat_ctr[STAT_PEAK_OCC] = 64'(link_q.size());
				if (byte_cnt > stat_ctr[STAT_PEAK_BYTES])
					stat_ctr[STAT_PEAK_BYTES] = byte_cnt;
			end
		end else if (ev.sel < STAT_NUM) begin
			r.stat_value = stat_ctr[ev.sel];
		end else if (ev.sel == STAT_CUR_TIME) begin
			r.stat_value = 64'(cur_time);
		end
		r.departure_time = dep[TIME_W-1:0];
		r.retired_count = n_ret;
		r.occupancy = CNT_O_W'(link_q.size());
		r.buffered_bytes = byte_cnt[BYT_O_W-1:0];
		return r;
	endfunction

	task automatic log_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0d] mismatch on %s: got %0h, expected %0h", cycles, what, got, want);
		errors++;
	endtask

	always @(negedge clk) begin : result_check
		rsp_t e;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				log_mismatch("unexpected result status", 64'(rsp_ch.status), '0);
			end else begin
				e = pending_rsp.pop_front();
				if (rsp_ch.status !== e.status)
					log_mismatch("status", 64'(rsp_ch.status), 64'(e.status));
				if (rsp_ch.departure_time !== e.departure_time)
					log_mismatch("departure_time", 64'(rsp_ch.departure_time),
						64'(e.departure_time));
				if (rsp_ch.retired_count !== e.retired_count)
					log_mismatch("retired_count", 64'(rsp_ch.retired_count),
						64'(e.retired_count));
				if (rsp_ch.occupancy !== e.occupancy)
					log_mismatch("occupancy", 64'(rsp_ch.occupancy), 64'(e.occupancy));
				if (rsp_ch.buffered_bytes !== e.buffered_bytes)
					log_mismatch("buffered_bytes", 64'(rsp_ch.buffered_bytes),
						64'(e.buffered_bytes));
				if (rsp_ch.stat_value !== e.stat_value)
					log_mismatch("stat_value", rsp_ch.stat_value, e.stat_value);
			end
		end
	end

	function automatic pkt_event_t mk(input logic op, input logic [63:0] t,
		input int unsigned size, input int unsigned sel);
		pkt_event_t ev;
		ev.op = op;
		ev.t = t[TIME_W-1:0];
		ev.size = SIZE_W'(size);
		ev.sel = SEL_W'(sel);
		return ev;
	endfunction

	task automatic send_item(input pkt_event_t ev);
		logic took;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.op          <= ev.op;
		req_ch.event_time  <= ev.t;
		req_ch.packet_size <= ev.size;
		req_ch.stat_select <= ev.sel;
		do begin
			@(negedge clk);
			took = req_ch.ready;
			if (took)
				pending_rsp.push_back(buffer_step(ev));
			@(posedge clk);
		end while (!took);
	endtask

	// drop valid, drain all responses, then let the pipeline go quiet
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
		input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		logic done;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			rdata = prdata;
			@(posedge clk);
		end while (done !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_set(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] rd;
		logic [APB_DW-1:0] want;
		settle();
		apb_xfer(1'b1, addr, value, rd);
		apb_xfer(1'b0, addr, '0, rd);
		if (addr == ADDR_CAP) begin
			cap_reg = value[CAP_W-1:0];
			want = APB_DW'(value[CAP_W-1:0]);
		end else begin
			tpb_reg = value[TPB_W-1:0];
			want = APB_DW'(value[TPB_W-1:0]);
		end
		if (rd !== want)
			log_mismatch("register readback", 64'(rd), 64'(want));
	endtask

	task automatic test_reset_registers();
		logic [APB_DW-1:0] rd;
		apb_xfer(1'b0, ADDR_CAP, '0, rd);
		if (rd !== APB_DW'(CAP_RST))
			log_mismatch("capacity after reset", 64'(rd), 64'(CAP_RST));
		apb_xfer(1'b0, ADDR_TPB, '0, rd);
		if (rd !== APB_DW'(TPB_RST))
			log_mismatch("time_per_byte after reset", 64'(rd), 64'(TPB_RST));
		send_item(mk(OP_READ, 0, 0, STAT_CUR_TIME));
		send_item(mk(OP_READ, 0, 16'hFFFF, STAT_RX_PKTS));
		settle();
	endtask

	task automatic test_departure_edges();
		send_item(mk(OP_ARRIVE, 0, 0, 0));
		send_item(mk(OP_ARRIVE, 0, 16'hFFFF, 4'hF));
		send_item(mk(OP_READ, 10, 16'hFFFF, STAT_TX_PKTS));
		// departure saturates at the top of the time range
		send_item(mk(OP_ARRIVE, TIME_MAX - 48'd5, 100, 0));
		send_item(mk(OP_READ, TIME_MAX - 48'd5, 0, STAT_CUR_TIME));
		// time steps backwards
		send_item(mk(OP_ARRIVE, 1000, 1, 0));
		send_item(mk(OP_READ, TIME_MAX, 0, STAT_DELAY_SUM));
		settle();
	endtask

	task automatic test_capacity_edges();
		reg_set(ADDR_CAP, 0);
		send_item(mk(OP_ARRIVE, 2000, 7, 0));
		reg_set(ADDR_CAP, 1);
		send_item(mk(OP_ARRIVE, 5000, 10, 0));
		send_item(mk(OP_ARRIVE, 5000, 20, 0));
		reg_set(ADDR_CAP, 100);
		reg_set(ADDR_TPB, 0);
		send_item(mk(OP_ARRIVE, 6000, 50, 0));
		send_item(mk(OP_READ, 6000, 0, STAT_CUR_TIME + 1));
		send_item(mk(OP_READ, 6000, 0, STAT_CUR_TIME + 2));
		send_item(mk(OP_READ, TIME_MAX, 0, STAT_LOST_BYTES));
		settle();
	endtask

	// receiver held off while arrivals keep coming: buffer fills to depth
	task automatic test_backpressure_fill();
		reg_set(ADDR_CAP, 32'hFFFF_FFFF);
		reg_set(ADDR_TPB, 32'hFFFF_FFFF);
		idle_pct = 0;
		stall_pct <= 0;
		fork
			begin
				hold_rx <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx <= 1'b0;
			end
		join_none
		for (int i = 0; i < 140; i++)
			send_item(mk(OP_ARRIVE, 1000, $urandom_range(65535), $urandom_range(15)));
		send_item(mk(OP_READ, 1000, $urandom_range(65535), STAT_PEAK_BYTES));
		send_item(mk(OP_READ, TIME_MAX, $urandom_range(65535), STAT_BYTES_SUM));
		settle();
	endtask

	task automatic run_phase(input int unsigned cap, input int unsigned tpb,
		input int unsigned load, input int idle, input int stall, input int n);
		logic [63:0] scale;
		logic [63:0] delta;
		logic [63:0] t;
		int unsigned pick;
		int unsigned size;
		logic        op;
		reg_set(ADDR_CAP, cap);
		reg_set(ADDR_TPB, tpb);
		idle_pct = idle;
		stall_pct <= stall;
		scale = (tpb == 0) ? 64'd1 : 64'(tpb);
		now = ($urandom_range(3) == 0) ? {$urandom, $urandom} & 64'h0000_7FFF_FFFF_FFFF : '0;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(99) < 20) ? OP_READ : OP_ARRIVE;
			delta = ($urandom_range(99) < 15) ? '0 : 64'($urandom_range(load)) * scale;
			now = (now > 64'(TIME_MAX) - delta) ? 64'(TIME_MAX) : now + delta;
			t = now;
			if ($urandom_range(99) < 4) begin
				delta = 64'($urandom_range(load)) * scale;
				t = (now > delta) ? now - delta : '0;
			end
			pick = $urandom_range(99);
			if (pick < 5)
				size = 0;
			else if (pick < 10)
				size = 16'hFFFF;
			else if (pick < 25)
				size = $urandom_range(65535);
			else
				size = $urandom_range(1500);
			send_item(mk(op, t, size, $urandom_range(15)));
		end
		send_item(mk(OP_READ, TIME_MAX, $urandom_range(65535), $urandom_range(15)));
		settle();
	endtask

	task automatic test_random_traffic();
		run_phase(100, 1600, 800, 0, 0, 115);
		run_phase(1, 1, 50, 57, 0, 115);
		run_phase(128, 3, 300, 0, 57, 115);
		run_phase(255, 20, 2000, 16, 16, 115);
		run_phase(0, 5, 100, 0, 0, 115);
		run_phase(2, 1048575, 1500, 57, 0, 115);
		run_phase(17, 0, 10, 0, 57, 115);
		run_phase(64, 40, 5000, 16, 16, 115);
	endtask

	initial begin
		for (int i = 0; i < STAT_NUM; i++)
			stat_ctr[i] = '0;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_ARRIVE;
		req_ch.event_time <= '0;
		req_ch.packet_size <= '0;
		req_ch.stat_select <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_registers();
		test_departure_edges();
		test_capacity_edges();
		test_backpressure_fill();
		test_random_traffic();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
